// ===== src/owcp_pkg.sv =====
// Shared types and constants for the OLED waveform column plotter.
// Used by the front, job queue, back and top-level modules.
package owcp_pkg;

	localparam int NUM_COLUMNS = 128;
	localparam int COL_AW      = $clog2(NUM_COLUMNS);
	localparam int COL_W       = 7;
	localparam int SAMPLE_W    = 8;
	localparam int PAGE_W      = 3;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;
	localparam logic [7:0] NIBBLE_MASK   = 8'h0F;
	localparam logic [7:0] MASK_TOP      = 8'h80;
	localparam logic [7:0] ERASE_BYTE    = 8'h00;
	localparam logic [5:0] SAMPLE_MAX    = 6'd63;

	// One classified sample, handed from the front to the back.
	typedef struct packed {
		logic [COL_W-1:0]  col;
		logic [PAGE_W-1:0] old_page;
		logic [PAGE_W-1:0] new_page;
		logic [7:0]        mask;
		logic              erase;
	} job_t;

endpackage

// ===== src/owcp_front.sv =====
// Front end: accepts samples, maps them to page and mask, and classifies
// them against the per-column page store. Depends on owcp_pkg.
module owcp_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [owcp_pkg::COL_W-1:0]    column,
	input  logic [owcp_pkg::SAMPLE_W-1:0] sample,
	output logic                          job_valid,
	output owcp_pkg::job_t                job,
	input  logic                          job_full
);
	import owcp_pkg::*;

	logic                s1_valid_q;
	logic [COL_W-1:0]    col_s1;
	logic [PAGE_W-1:0]   page_s1;
	logic [7:0]          mask_s1;
	logic                in_range_s1;

	logic [PAGE_W-1:0]   page_mem_q [NUM_COLUMNS];
	logic [NUM_COLUMNS-1:0] written_q;
	logic [PAGE_W-1:0]   rd_page_q;
	logic                rd_written_q;
	logic                fwd_hit_q;
	logic [PAGE_W-1:0]   fwd_page_q;

	logic                accept;
	logic                drain;
	logic                wr_en;
	logic [COL_AW-1:0]   rd_idx;
	logic [COL_AW-1:0]   wr_idx;
	logic [5:0]          smp_sat;
	logic [PAGE_W-1:0]   old_page;

	assign smp_sat = (sample > SAMPLE_W'(SAMPLE_MAX)) ? SAMPLE_MAX : sample[5:0];
	assign rd_idx  = COL_AW'(column);
	assign wr_idx  = COL_AW'(col_s1);

	// The stage empties when its item is pushed to the queue or dropped.
	assign drain  = s1_valid_q && (!in_range_s1 || !job_full);
	assign wr_en  = drain && in_range_s1;
	assign full   = s1_valid_q && !drain;
	assign accept = push && !full;

	// A write landing on the same edge as the read is forwarded.
	assign old_page = fwd_hit_q ? fwd_page_q : (rd_written_q ? rd_page_q : '0);

	assign job_valid    = wr_en;
	assign job.col      = col_s1;
	assign job.old_page = old_page;
	assign job.new_page = page_s1;
	assign job.mask     = mask_s1;
	assign job.erase    = (old_page != page_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			written_q  <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (drain) begin
				s1_valid_q <= 1'b0;
			end
			if (wr_en) begin
				written_q[wr_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			col_s1       <= column;
			page_s1      <= ~smp_sat[5:3];
			mask_s1      <= MASK_TOP >> smp_sat[2:0];
			in_range_s1  <= (32'(column) < NUM_COLUMNS);
			rd_page_q    <= page_mem_q[rd_idx];
			rd_written_q <= written_q[rd_idx];
			fwd_hit_q    <= wr_en && (col_s1 == column);
			fwd_page_q   <= page_s1;
		end
		if (wr_en) begin
			page_mem_q[wr_idx] <= page_s1;
		end
	end

endmodule

// ===== src/owcp_fifo.sv =====
// Short job queue between the front and the back.
// Depends on owcp_pkg for the job type and depth.
module owcp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  owcp_pkg::job_t in_job,
	output logic           full,
	input  logic           pop,
	output owcp_pkg::job_t head,
	output logic           empty
);
	import owcp_pkg::*;

	job_t               jobs_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_AW:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign full    = (count_q == (FIFO_AW+1)'(FIFO_DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = in_valid && !full;
	assign do_pop  = pop && !empty;
	assign head    = jobs_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			jobs_q[wr_ptr_q] <= in_job;
		end
	end

endmodule

// ===== src/owcp_back.sv =====
// Back end: steps through the erase and draw byte sequences of each job
// and holds the current byte in the output register. Depends on owcp_pkg.
module owcp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_empty,
	input  owcp_pkg::job_t job,
	output logic           job_pop,
	output logic           empty,
	input  logic           pop,
	output logic           is_data,
	output logic [7:0]     out_byte,
	output logic           last
);
	import owcp_pkg::*;

	typedef enum logic [1:0] {
		SLOT_PAGE   = 2'd0,
		SLOT_COL_LO = 2'd1,
		SLOT_COL_HI = 2'd2,
		SLOT_DATA   = 2'd3
	} slot_t;

	logic       out_valid_q;
	logic [7:0] byte_q;
	logic       is_data_q;
	logic       last_q;
	logic [2:0] cnt_q;

	logic       load;
	logic [2:0] pos;
	logic       draw;
	logic [7:0] nxt_byte;
	logic       nxt_is_data;
	logic       nxt_last;

	// Jobs without an erase start directly at the draw half.
	assign pos  = {cnt_q[2] | ~job.erase, cnt_q[1:0]};
	assign draw = pos[2];
	assign load = !job_empty && (!out_valid_q || pop);

	always_comb begin
		nxt_is_data = 1'b0;
		nxt_last    = 1'b0;
		case (slot_t'(pos[1:0]))
			SLOT_PAGE:   nxt_byte = CMD_PAGE_BASE |
				{5'b0, (draw ? job.new_page : job.old_page)};
			SLOT_COL_LO: nxt_byte = {1'b0, job.col} & NIBBLE_MASK;
			SLOT_COL_HI: nxt_byte = CMD_COL_HIGH | {5'b0, job.col[6:4]};
			SLOT_DATA: begin
				nxt_byte    = draw ? job.mask : ERASE_BYTE;
				nxt_is_data = 1'b1;
				nxt_last    = draw;
			end
			default:     nxt_byte = ERASE_BYTE;
		endcase
	end

	assign job_pop  = load && nxt_last;
	assign empty    = !out_valid_q;
	assign is_data  = is_data_q;
	assign out_byte = byte_q;
	assign last     = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				cnt_q       <= nxt_last ? 3'd0 : cnt_q + 3'd1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q    <= nxt_byte;
			is_data_q <= nxt_is_data;
			last_q    <= nxt_last;
		end
	end

endmodule

// ===== src/oled_waveform_column_plotter.sv =====
// Top level of the OLED waveform column plotter.
// Instantiates owcp_front, owcp_fifo and owcp_back; depends on owcp_pkg.
//
//   Channel   Handshake            Payload
//   -------   ------------------   ------------------------------
//   samples   push / full          column[6:0], sample[7:0]
//   bytes     empty / pop          is_data, out_byte[7:0], last
//
// Each sample turns into four bytes (draw only) or eight bytes (erase of the
// old page, then draw). The output register moves one byte per cycle while
// pop takes it, so the byte port sets the rate.
// The first byte of a sample passes the front stage, the job queue and the
// output register before it is on the byte port.
// Reset clears the written flag of every column at once, so no clearing pass
// is needed and samples can be taken as soon as reset is released.
// A four-entry job queue lets the front keep accepting while pop stalls.
module oled_waveform_column_plotter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [owcp_pkg::COL_W-1:0]    column,
	input  logic [owcp_pkg::SAMPLE_W-1:0] sample,
	output logic                          empty,
	input  logic                          pop,
	output logic                          is_data,
	output logic [7:0]                    out_byte,
	output logic                          last
);
	import owcp_pkg::*;

	// The front maps the sample to a page and bit mask, looks up the page
	// last drawn in that column (with forwarding from the write of the item
	// ahead), updates the store, and classifies the job as draw or
	// erase-plus-draw.
	logic job_valid;
	job_t front_job;
	logic job_full;

	// The back pulls jobs from the queue and walks through their bytes.
	job_t head_job;
	logic job_empty;
	logic job_pop;

	owcp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.column    (column),
		.sample    (sample),
		.job_valid (job_valid),
		.job       (front_job),
		.job_full  (job_full)
	);

	owcp_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (job_valid),
		.in_job   (front_job),
		.full     (job_full),
		.pop      (job_pop),
		.head     (head_job),
		.empty    (job_empty)
	);

	owcp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_empty (job_empty),
		.job       (head_job),
		.job_pop   (job_pop),
		.empty     (empty),
		.pop       (pop),
		.is_data   (is_data),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

// ===== src/owcp_checker.sv =====
// Port-level checks for the OLED waveform column plotter, bound to the top.
// Depends only on the top-level ports.
module owcp_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       empty,
	input logic       pop,
	input logic       is_data,
	input logic [7:0] out_byte,
	input logic       last
);

	// A stalled byte stays on the port unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(is_data)
			&& $stable(last)))
		else $error("result changed while stalled");

	// A command byte never closes a sample's sequence.
	a_cmd_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !is_data) |-> !last)
		else $error("command byte marked last");

	// A data byte that is not last belongs to an erase and must be zero.
	a_erase_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && is_data && !last) |-> (out_byte == 8'h00))
		else $error("erase data byte not zero");

	// After a page command is taken, the next shown byte is a low column command.
	a_page_then_col: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !is_data && out_byte[7:4] == 4'hB)
			|=> (empty || (!is_data && out_byte[7:4] == 4'h0)))
		else $error("page command not followed by column command");

endmodule

bind oled_waveform_column_plotter owcp_checker u_owcp_checker (.*);

// ===== sim/owcp_byte_checker.sv =====
// Scoreboard for the OLED waveform column plotter: watches the sample and byte channels.
// It keeps its own copy of the per-column page store and compares every popped byte.
// Depends on owcp_pkg for widths and command constants.
module owcp_byte_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	input  logic                          full,
	input  logic [owcp_pkg::COL_W-1:0]    column,
	input  logic [owcp_pkg::SAMPLE_W-1:0] sample,
	input  logic                          empty,
	input  logic                          pop,
	input  logic                          is_data,
	input  logic [7:0]                    out_byte,
	input  logic                          last,
	output int                            errors,
	output int                            pending,
	output int                            samples_seen,
	output int                            bytes_seen,
	output int                            erases_seen
);
	import owcp_pkg::*;

	typedef struct packed {
		logic       is_data;
		logic [7:0] out_byte;
		logic       last;
	} oled_byte_t;

	oled_byte_t        expected_bytes[$];
	logic [PAGE_W-1:0] page_drawn [NUM_COLUMNS];

	int mismatches      = 0;
	int outstanding     = 0;
	int samples_plotted = 0;
	int bytes_checked   = 0;
	int erases          = 0;

	assign errors       = mismatches;
	assign pending      = outstanding;
	assign samples_seen = samples_plotted;
	assign bytes_seen   = bytes_checked;
	assign erases_seen  = erases;

	// Page address, low and high column nibbles, then one data byte.
	task automatic queue_sequence(input logic [PAGE_W-1:0] page, input logic [COL_W-1:0] col,
			input logic [7:0] data, input logic closes);
		expected_bytes.push_back({1'b0, CMD_PAGE_BASE + {5'd0, page}, 1'b0});
		expected_bytes.push_back({1'b0, {4'd0, col[3:0]}, 1'b0});
		expected_bytes.push_back({1'b0, CMD_COL_HIGH + {5'd0, col[COL_W-1:4]}, 1'b0});
		expected_bytes.push_back({1'b1, data, closes});
	endtask

	// Maps one sample to its pixel and queues the erase and draw bytes it causes.
	task automatic plot_sample(input logic [COL_W-1:0] col, input logic [SAMPLE_W-1:0] smp);
		logic [5:0]        height;
		logic [PAGE_W-1:0] page;
		logic [7:0]        mask;
		if (int'(col) >= NUM_COLUMNS)
			return;
		height = (smp > SAMPLE_MAX) ? SAMPLE_MAX : smp[5:0];
		page   = 3'd7 - height[5:3];
		mask   = MASK_TOP >> height[2:0];
		samples_plotted++;
		if (page_drawn[col] != page) begin
			erases++;
			queue_sequence(page_drawn[col], col, ERASE_BYTE, 1'b0);
		end
		queue_sequence(page, col, mask, 1'b1);
		page_drawn[col] = page;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		oled_byte_t got;
		oled_byte_t want;
		if (!arst_n) begin
			for (int i = 0; i < NUM_COLUMNS; i++)
				page_drawn[i] = '0;
			expected_bytes.delete();
		end else begin
			if (pop && !empty) begin
				got = {is_data, out_byte, last};
				bytes_checked++;
				if (expected_bytes.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected byte, expected none, got is_data=%0b out_byte=%02h last=%0b",
						$time, got.is_data, got.out_byte, got.last);
				end else begin
					want = expected_bytes.pop_front();
					if (got.is_data !== want.is_data) begin
						mismatches++;
						$display("%0t: is_data expected %0b, got %0b",
							$time, want.is_data, got.is_data);
					end
					if (got.out_byte !== want.out_byte) begin
						mismatches++;
						$display("%0t: out_byte expected %02h, got %02h",
							$time, want.out_byte, got.out_byte);
					end
					if (got.last !== want.last) begin
						mismatches++;
						$display("%0t: last expected %0b, got %0b", $time, want.last, got.last);
					end
				end
			end
			if (push && !full)
				plot_sample(column, sample);
		end
		outstanding = expected_bytes.size();
	end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the OLED waveform column plotter: clock, reset, stimulus and verdict.
// Instantiates oled_waveform_column_plotter and owcp_byte_checker; depends on owcp_pkg.
module tb;
	import owcp_pkg::*;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                push     = 1'b0;
	logic [COL_W-1:0]    column   = '0;
	logic [SAMPLE_W-1:0] sample   = '0;
	logic                pop      = 1'b0;
	logic                full;
	logic                empty;
	logic                is_data;
	logic [7:0]          out_byte;
	logic                last;

	// Traffic shaping knobs; the two rates are in percent of cycles. The hold
	// counter freezes the byte reader for a number of cycles and is counted down by the reader.
	int send_idle_pct = 0;
	int stall_pct     = 0;
	int hold_cycles   = 0;

	int err_count;
	int pending_bytes;
	int sample_count;
	int byte_count;
	int erase_count;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	oled_waveform_column_plotter u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.column   (column),
		.sample   (sample),
		.empty    (empty),
		.pop      (pop),
		.is_data  (is_data),
		.out_byte (out_byte),
		.last     (last)
	);

	// The checker sees exactly what the block sees and does all the scoring.
	owcp_byte_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.column       (column),
		.sample       (sample),
		.empty        (empty),
		.pop          (pop),
		.is_data      (is_data),
		.out_byte     (out_byte),
		.last         (last),
		.errors       (err_count),
		.pending      (pending_bytes),
		.samples_seen (sample_count),
		.bytes_seen   (byte_count),
		.erases_seen  (erase_count)
	);

	// Offers one sample and returns once the transaction has happened. Push is
	// left high, so back-to-back samples keep it asserted without a glitch; the
	// idle loop lowers it only when the sender decides to pause.
	task automatic send_sample(input logic [COL_W-1:0] col, input logic [SAMPLE_W-1:0] smp);
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push   <= 1'b1;
		column <= col;
		sample <= smp;
		do @(posedge clk); while (full);
	endtask

	// Random samples. A good share lands on a handful of columns so that the
	// same column is revisited often, which mixes draws that keep the page with
	// draws that first erase the old one. About one in ten samples is above the
	// saturation point.
	task automatic send_random(input int count);
		logic [COL_W-1:0]    col;
		logic [SAMPLE_W-1:0] smp;
		int                  pick;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(9);
			col  = (pick < 4) ? COL_W'($urandom_range(7)) : COL_W'($urandom);
			smp  = (pick == 9) ? SAMPLE_W'($urandom_range(255, 64)) : SAMPLE_W'($urandom_range(63));
			send_sample(col, smp);
		end
	endtask

	// Byte reader. Pop is redrawn every cycle from the stall rate, except while
	// a hold is in progress, during which it stays low.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				pop <= 1'b0;
				hold_cycles--;
			end else begin
				pop <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed samples. Every column starts at page 0 after reset, so the
		// first sample at height 0 must erase page 0 before drawing page 7,
		// while a first sample at the top of the range draws without an erase.
		send_sample(7'd0, 8'd0);
		send_sample(7'd0, 8'd0);       // same page again: draw only
		send_sample(7'd0, 8'd63);      // page 7 to page 0: erase first
		send_sample(7'd0, 8'd255);     // saturates to 63, page unchanged
		send_sample(7'd0, 8'd64);      // just above the saturation point
		send_sample(7'd127, 8'd128);   // last column, fresh, saturated
		send_sample(7'd127, 8'd7);     // page 7, lowest pixel of the page
		send_sample(7'd127, 8'd8);     // page 6, top pixel of the page
		send_sample(7'd85, 8'd1);
		send_sample(7'd85, 8'd2);
		send_sample(7'd85, 8'd4);
		send_sample(7'd85, 8'd16);
		send_sample(7'd85, 8'd32);
		send_sample(7'd42, 8'd170);
		send_sample(7'd42, 8'd85);
		send_sample(7'd42, 8'd56);     // page 0, mask of the top bit
		send_sample(7'd1, 8'd15);
		send_sample(7'd2, 8'd47);
		send_sample(7'd64, 8'd24);

		// Random traffic in phases: free flow, sender gaps, reader stalls, then both.
		send_random(45);
		send_idle_pct = 66;
		send_random(45);
		send_idle_pct = 0;
		stall_pct     = 66;
		send_random(45);
		send_idle_pct = 21;
		stall_pct     = 21;
		send_random(45);

		// The reader holds off for a long stretch while samples keep coming, so
		// the job queue fills and full must push back on the sender.
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_cycles   = 300;
		send_random(50);
		push <= 1'b0;

		// Drain, sampling the count away from the active edge, then keep the clock
		// running so that any stray byte from the block would still show.
		do @(negedge clk); while (pending_bytes != 0);
		repeat (20) @(posedge clk);

		$display("Plotted %0d samples into %0d display bytes; %0d of them erased an older page.",
			sample_count, byte_count, erase_count);
		$display("Traffic ran free, with sender gaps, reader stalls, both, and a long reader hold.");
		if (err_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog, far beyond the slowest correct run.
	initial begin
		#2400000;
		$display("Some tests failed");
		$finish;
	end

endmodule
